### sv/plf_pkg.sv
// Package for the printer line formatter: shared constants and types.
// No dependencies.
package plf_pkg;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_RSTP  = 2'd1;
  localparam logic [1:0] OP_WORD  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_NL    = 8'd10;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_PRINT = 3'd1,
    CMD_BS    = 3'd2,
    CMD_EOL   = 3'd3,
    CMD_RSTP  = 3'd4,
    CMD_WORD  = 3'd5
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
  } cmd_t;

endpackage

### sv/plf_front.sv
// Front end: accepts input transactions, classifies them, queues commands.
// Depends on plf_pkg.
module plf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        data_byte_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output plf_pkg::cmd_t     cmd_o
);
  import plf_pkg::*;

  localparam int Depth = 2;

  cmd_t       fifo_q [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.ch  = data_byte_i;
    cls.cmd = CMD_NONE;
    unique case (opcode_i)
      OP_DATA: begin
        if (data_byte_i == CH_CR || data_byte_i == CH_LF || data_byte_i == CH_VT) begin
          cls.cmd = CMD_EOL;
        end else if (data_byte_i == CH_BS) begin
          cls.cmd = CMD_BS;
        end else if (data_byte_i >= CH_SPACE) begin
          cls.cmd = CMD_PRINT;
        end
      end
      OP_RSTP: cls.cmd = CMD_RSTP;
      OP_WORD: cls.cmd = CMD_WORD;
      default: cls.cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'(Depth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];
  assign push        = in_valid_i && in_ready_o && (cls.cmd != CMD_NONE);
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### sv/plf_back.sv
// Back end: row store, cursor, line trim and packed line output.
// Depends on plf_pkg.
module plf_back #(
  parameter int RowWidth       = 120,
  parameter int BytesPerResult = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  plf_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       chars_o,
  output logic [3:0]        char_count_o,
  output logic              last_o
);
  import plf_pkg::*;

  localparam int CW = $clog2(RowWidth + 1);
  localparam int IW = $clog2(RowWidth);
  localparam int BW = $clog2(BytesPerResult + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [7:0]    mem_q [RowWidth];
  logic [7:0]    rdata_q;
  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [IW-1:0] first_q, first_d, lastc_q, lastc_d;
  logic          found_q, found_d;
  logic [CW-1:0] left_q, left_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic          par_q, par_d, word_q, word_d;
  logic [63:0]   acc_q, acc_d;
  logic [BW-1:0] n_q, n_d;
  logic          nl_q, nl_d;
  logic          ov_q, ov_d;
  logic [63:0]   och_q, och_d;
  logic [3:0]    ocnt_q, ocnt_d;
  logic          olast_q, olast_d;
  logic          lout_q, lout_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [7:0]    wdata;
  logic [7:0]    byte_in;
  logic          full;

  assign cmd_ready_o  = (st_q == S_IDLE);
  assign out_valid_o  = ov_q;
  assign chars_o      = och_q;
  assign char_count_o = ocnt_q;
  assign last_o       = lout_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    st_d = st_q; cur_d = cur_q; idx_d = idx_q; first_d = first_q; lastc_d = lastc_q;
    found_d = found_q; left_d = left_q; ptr_d = ptr_q; par_d = par_q; word_d = word_q;
    acc_d = acc_q; n_d = n_q; nl_d = nl_q; ov_d = ov_q; och_d = och_q; ocnt_d = ocnt_q;
    olast_d = olast_q; lout_d = lout_q;
    we = 1'b0; waddr = cur_q[IW-1:0]; wdata = cmd_i.ch; raddr = idx_q[IW-1:0];
    byte_in = nl_q ? CH_NL : rdata_q;
    full = (n_q == BW'(BytesPerResult));
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.cmd)
            CMD_PRINT: begin
              if (cur_q < CW'(RowWidth)) begin
                we = 1'b1;
                cur_d = cur_q + 1'b1;
              end
            end
            CMD_BS: if (cur_q != '0) cur_d = cur_q - 1'b1;
            CMD_RSTP: par_d = 1'b0;
            CMD_WORD: begin
              par_d = 1'b0;
              word_d = 1'b1;
            end
            CMD_EOL: begin
              idx_d = '0;
              found_d = 1'b0;
              st_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        raddr = idx_q[IW-1:0];
        if (idx_q != '0) begin
          if (rdata_q != CH_SPACE) begin
            if (!found_q) first_d = IW'(idx_q - 1'b1);
            lastc_d = IW'(idx_q - 1'b1);
            found_d = 1'b1;
          end
        end
        if (idx_q == CW'(RowWidth)) begin
          if (!found_d) begin
            idx_d = '0;
            st_d = S_CLR;
          end else begin
            left_d = CW'(lastc_d - first_d) + 1'b1;
            ptr_d = par_q ? lastc_d : first_d;
            acc_d = '0; n_d = '0; nl_d = 1'b0;
            st_d = S_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_RD: begin
        raddr = ptr_q;
        st_d = S_ACC;
      end
      S_ACC: begin
        if (!full) begin
          acc_d = acc_q | (64'(byte_in) << (8 * n_q));
          n_d = n_q + 1'b1;
          if (nl_q) begin
            st_d = S_OUT;
            nl_d = 1'b0;
            olast_d = 1'b1;
          end else begin
            left_d = left_q - 1'b1;
            ptr_d = par_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
            if (left_q == CW'(1)) nl_d = 1'b1;
            if (n_q == BW'(BytesPerResult - 1)) begin
              st_d = S_OUT;
              olast_d = 1'b0;
            end else if (left_q != CW'(1)) begin
              st_d = S_RD;
            end
          end
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          och_d = acc_q;
          ocnt_d = 4'(n_q);
          lout_d = olast_q;
          acc_d = '0;
          n_d = '0;
          if (olast_q) begin
            if (word_q) par_d = ~par_q;
            idx_d = '0;
            st_d = S_CLR;
          end else begin
            st_d = nl_q ? S_ACC : S_RD;
          end
        end
      end
      S_CLR: begin
        we = 1'b1;
        waddr = idx_q[IW-1:0];
        wdata = CH_SPACE;
        if (idx_q == CW'(RowWidth - 1)) begin
          cur_d = '0;
          st_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; idx_q <= '0; cur_q <= '0; par_q <= 1'b0; word_q <= 1'b0;
      ov_q <= 1'b0; found_q <= 1'b0; nl_q <= 1'b0; n_q <= '0; olast_q <= 1'b0;
      lout_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; cur_q <= cur_d; par_q <= par_d; word_q <= word_d;
      ov_q <= ov_d; found_q <= found_d; nl_q <= nl_d; n_q <= n_d; olast_q <= olast_d;
      lout_q <= lout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d; lastc_q <= lastc_d; left_q <= left_d; ptr_q <= ptr_d;
    acc_q <= acc_d; och_q <= och_d; ocnt_q <= ocnt_d;
  end

endmodule

### sv/printer_line_formatter_unit.sv
// Printer line formatter: builds a text row from printer bytes and emits trimmed
// lines packed into words. A front end classifies bytes into a two-entry command
// queue; a back end owns the row memory. Printable, backspace and mode bytes are
// handled while the back end is idle. A line end scans the row, reads out each row
// byte and then the newline, emits each result once the previous one has been taken,
// and then clears the row; the same clearing pass runs after reset.
// Depends on plf_pkg.
module printer_line_formatter_unit #(
  parameter int ROW_WIDTH        = 120,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] chars_o,
  output logic [3:0]  char_count_o,
  output logic        last_o
);
  import plf_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  plf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .data_byte_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  plf_back #(.RowWidth(ROW_WIDTH), .BytesPerResult(BYTES_PER_RESULT)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .chars_o, .char_count_o, .last_o
  );

endmodule

### verif/tb_printer_line_formatter_unit.sv
// Testbench for printer_line_formatter_unit: directed table then random byte streams,
// checked against an in-bench line formatter model. Depends on plf_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_printer_line_formatter_unit;
  import plf_pkg::*;

  localparam int ROW_W = 120;
  localparam int BPR = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [63:0] chars;
    logic [3:0]  count;
    logic        last;
  } chunk_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
    bit         has_exp;
    logic [63:0] exp_chars;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = OP_DATA;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] chars_o;
  logic [3:0]  char_count_o;
  logic        last_o;

  printer_line_formatter_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .opcode_i(opcode_i), .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .chars_o(chars_o), .char_count_o(char_count_o), .last_o(last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0] row_mem [ROW_W];
  int         col;
  bit         parity;
  bit         wmode;
  chunk_t     pending_chunks[$];
  int         fail_cnt = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         recv_hold = 1'b0;
  bit         in_busy = 1'b0;

  function automatic void clear_row();
    foreach (row_mem[i]) row_mem[i] = CH_SPACE;
    col = 0;
  endfunction

  function automatic void format_byte(logic [1:0] op, logic [7:0] b);
    int first, lastc, len, pos, n;
    logic [7:0] line [ROW_W + 1];
    chunk_t ck;
    first = -1;
    lastc = -1;
    if (op == OP_RSTP) begin
      parity = 1'b0;
    end else if (op == OP_WORD) begin
      wmode = 1'b1;
      parity = 1'b0;
    end else if (op == OP_DATA) begin
      if (b == CH_CR || b == CH_LF || b == CH_VT) begin
        for (int i = 0; i < ROW_W; i++) begin
          if (row_mem[i] != CH_SPACE) begin
            if (first < 0) first = i;
            lastc = i;
          end
        end
        if (first >= 0) begin
          len = lastc - first + 1;
          for (int i = 0; i < len; i++)
            line[i] = parity ? row_mem[lastc - i] : row_mem[first + i];
          line[len] = CH_NL;
          len++;
          for (pos = 0; pos < len; pos += BPR) begin
            n = (len - pos > BPR) ? BPR : len - pos;
            ck.chars = '0;
            for (int k = 0; k < n; k++) ck.chars[8*k +: 8] = line[pos + k];
            ck.count = 4'(n);
            ck.last = (pos + n >= len);
            pending_chunks.push_back(ck);
          end
          if (wmode) parity = ~parity;
        end
        clear_row();
      end else if (b == CH_BS) begin
        if (col > 0) col--;
      end else if (b >= CH_SPACE) begin
        if (col < ROW_W) begin
          row_mem[col] = b;
          col++;
        end
      end
    end
  endfunction

  task automatic stop_in();
    if (in_busy) begin
      in_valid_i <= 1'b0;
      in_busy = 1'b0;
    end
  endtask

  task automatic send_byte(logic [1:0] op, logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      stop_in();
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_busy = 1'b1;
    opcode_i <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    format_byte(op, b);
  endtask

  task automatic drain_lines();
    stop_in();
    while (pending_chunks.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_text(int len, bit eol);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(19))
        0: send_byte(OP_DATA, CH_BS);
        1: send_byte(OP_DATA, 8'($urandom_range(31)));
        2, 3, 4: send_byte(OP_DATA, CH_SPACE);
        default: send_byte(OP_DATA, 8'($urandom_range(255, 33)));
      endcase
    end
    if (eol) begin
      case ($urandom_range(2))
        0: send_byte(OP_DATA, CH_CR);
        1: send_byte(OP_DATA, CH_LF);
        default: send_byte(OP_DATA, CH_VT);
      endcase
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    chunk_t ck;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chunks.size() == 0) begin
        $error("unexpected transaction chars=%h", chars_o);
        fail_cnt++;
      end else begin
        ck = pending_chunks.pop_front();
        if (chars_o !== ck.chars) begin
          $error("chars expected %h actual %h", ck.chars, chars_o);
          fail_cnt++;
        end
        if (char_count_o !== ck.count) begin
          $error("char_count expected %0d actual %0d", ck.count, char_count_o);
          fail_cnt++;
        end
        if (last_o !== ck.last) begin
          $error("last expected %0d actual %0d", ck.last, last_o);
          fail_cnt++;
        end
      end
    end
    out_ready_i <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  stim_t dir_tab[$];

  task automatic add_row(logic [1:0] op, logic [7:0] b, bit he, logic [63:0] ec);
    stim_t s;
    s.op = op;
    s.b = b;
    s.has_exp = he;
    s.exp_chars = ec;
    dir_tab.push_back(s);
  endtask

  initial begin
    parity = 1'b0;
    wmode = 1'b0;
    clear_row();
    add_row(OP_DATA, CH_CR, 1'b0, '0);
    add_row(OP_DATA, 8'hFF, 1'b0, '0);
    add_row(OP_DATA, 8'h21, 1'b0, '0);
    add_row(OP_DATA, CH_LF, 1'b1, 64'h0A_21_FF);
    add_row(OP_DATA, CH_BS, 1'b0, '0);
    add_row(OP_DATA, CH_SPACE, 1'b0, '0);
    add_row(OP_DATA, 8'h41, 1'b0, '0);
    add_row(OP_DATA, 8'h05, 1'b0, '0);
    add_row(OP_DATA, 8'h1F, 1'b0, '0);
    add_row(OP_DATA, CH_BS, 1'b0, '0);
    add_row(OP_DATA, 8'h42, 1'b0, '0);
    add_row(OP_DATA, 8'h80, 1'b0, '0);
    add_row(OP_DATA, CH_VT, 1'b1, 64'h0A_80_42);
    add_row(OP_WORD, 8'hAA, 1'b0, '0);
    add_row(OP_DATA, 8'h31, 1'b0, '0);
    add_row(OP_DATA, 8'h32, 1'b0, '0);
    add_row(OP_DATA, CH_CR, 1'b1, 64'h0A_32_31);
    add_row(OP_DATA, 8'h31, 1'b0, '0);
    add_row(OP_DATA, 8'h32, 1'b0, '0);
    add_row(OP_DATA, CH_CR, 1'b1, 64'h0A_31_32);
    add_row(OP_DATA, 8'h33, 1'b0, '0);
    add_row(OP_RSTP, 8'h55, 1'b0, '0);
    add_row(2'd3, 8'h0D, 1'b0, '0);
    add_row(OP_DATA, CH_LF, 1'b1, 64'h0A_33);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].op, dir_tab[i].b);
      if (dir_tab[i].has_exp && pending_chunks.size() != 0 &&
          pending_chunks[pending_chunks.size() - 1].chars !== dir_tab[i].exp_chars) begin
        $error("chars expected %h actual %h", dir_tab[i].exp_chars,
               pending_chunks[pending_chunks.size() - 1].chars);
        fail_cnt++;
      end
    end

    // full row plus overflow, both parities
    for (int i = 0; i < ROW_W + 3; i++) send_byte(OP_DATA, 8'($urandom_range(255, 33)));
    send_byte(OP_DATA, CH_CR);
    for (int i = 0; i < ROW_W; i++) send_byte(OP_DATA, 8'($urandom_range(255, 33)));
    send_byte(OP_DATA, CH_LF);
    drain_lines();

    // long receiver stall while input keeps coming
    recv_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      begin
        for (int j = 0; j < 4; j++) send_text(20, 1'b1);
        stop_in();
      end
    join

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 6 : 0;
      for (int j = 0; j < 5; j++) begin
        case ($urandom_range(9))
          0: send_byte(OP_RSTP, 8'($urandom));
          1: send_byte(OP_WORD, 8'($urandom));
          2: send_byte(2'd3, 8'($urandom));
          3: send_byte(OP_DATA, 8'($urandom));
          default: ;
        endcase
        send_text($urandom_range(12), 1'b1);
      end
      drain_lines();
    end

    drain_lines();
    repeat (400) @(posedge clk_i);
    if (fail_cnt == 0 && pending_chunks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
